FILE: rtl/core/set_assoc_cache_replacement_core_defines.svh
// Assertion macros for the cache replacement core
`ifndef SET_ASSOC_CACHE_REPLACEMENT_CORE_DEFINES_SVH
`define SET_ASSOC_CACHE_REPLACEMENT_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define SACR_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define SACR_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`define SACR_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define SACR_ASSERT(lbl, expr, msg)
`define SACR_ASSERT_IMPL(lbl, pre, post, msg)
`define SACR_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

FILE: rtl/core/sacr_pkg.sv
`default_nettype none

package sacr_pkg;

  localparam int ADDRESS_W     = 16;
  localparam int SET_INDEX_W   = 2;
  localparam int WAY_OUT_W     = 2;
  localparam int WORD_OFFSET_W = 2;
  localparam int COUNT_W       = 16;
  localparam int POLICY_W      = 2;

  localparam int DEF_NUM_BLOCKS      = 16;
  localparam int DEF_NUM_WAYS        = 4;
  localparam int DEF_WORDS_PER_BLOCK = 4;
  localparam int DEF_ADDR_BITS       = 16;
  localparam int DEF_AGE_BITS        = 16;

  localparam logic [POLICY_W-1:0] POLICY_FIFO = 2'd0;
  localparam logic [POLICY_W-1:0] POLICY_LRU  = 2'd1;
  localparam logic [POLICY_W-1:0] POLICY_MRU  = 2'd2;

endpackage

`default_nettype wire

FILE: rtl/core/sacr_ram.sv
`default_nettype none

module sacr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  output logic [WIDTH-1:0]                             rdata_a,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic [WIDTH-1:0]                             rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

FILE: rtl/core/set_assoc_cache_replacement_core.sv
// An accepted item passes through the states READ, LOOK and UPDATE before out_valid is set
// (set read, tag compare and age evaluation, victim select and write-back).
// No new item is accepted before the read-modify-write of one set row completes in UPDATE.
// Ages are kept as access stamps; one set per item is swept to mark saturated ages.
// Reset: synchronous; a clearing pass that writes each set in turn (four by default) follows,
// during which no item is accepted.
`default_nettype none
`include "set_assoc_cache_replacement_core_defines.svh"

module set_assoc_cache_replacement_core #(
  parameter int NUM_BLOCKS      = sacr_pkg::DEF_NUM_BLOCKS,
  parameter int NUM_WAYS        = sacr_pkg::DEF_NUM_WAYS,
  parameter int WORDS_PER_BLOCK = sacr_pkg::DEF_WORDS_PER_BLOCK,
  parameter int ADDR_BITS       = sacr_pkg::DEF_ADDR_BITS,
  parameter int AGE_BITS        = sacr_pkg::DEF_AGE_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [sacr_pkg::POLICY_W-1:0]       cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [sacr_pkg::ADDRESS_W-1:0]      address,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                hit,
  output logic [sacr_pkg::SET_INDEX_W-1:0]    set_index,
  output logic [sacr_pkg::WAY_OUT_W-1:0]      way,
  output logic [sacr_pkg::WORD_OFFSET_W-1:0]  word_offset,
  output logic                                evicted,
  output logic [sacr_pkg::COUNT_W-1:0]        hit_count,
  output logic [sacr_pkg::COUNT_W-1:0]        miss_count
);

  import sacr_pkg::*;

  localparam int WPB    = WORDS_PER_BLOCK;
  localparam int SETS   = ((NUM_BLOCKS / NUM_WAYS) > 0) ? (NUM_BLOCKS / NUM_WAYS) : 1;
  localparam int AW     = (ADDR_BITS < ADDRESS_W) ? ADDR_BITS : ADDRESS_W;
  localparam int OFF_W  = (WPB > 1) ? $clog2(WPB) : 1;
  localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int WAYS_P = 1 << WAY_W;

  localparam longint ADDR_MAX = (64'd1 << AW) - 64'd1;
  localparam longint BLK_MAX  = ADDR_MAX / WPB;
  localparam int     TAG_DIV  = WPB * SETS;
  localparam longint TAG_MAX  = ADDR_MAX / TAG_DIV;
  localparam int     BLK_W    = (BLK_MAX > 0) ? $clog2(BLK_MAX + 1) : 1;
  localparam int     TAG_W    = (TAG_MAX > 0) ? $clog2(TAG_MAX + 1) : 1;

  localparam int     BLK_SH  = AW + $clog2(WPB);
  localparam longint BLK_MUL = ((64'd1 << BLK_SH) + WPB - 1) / WPB;
  localparam int     BLK_PW  = BLK_SH + BLK_W;
  localparam int     TAG_SH  = AW + $clog2(TAG_DIV);
  localparam longint TAG_MUL = ((64'd1 << TAG_SH) + TAG_DIV - 1) / TAG_DIV;
  localparam int     TAG_PW  = TAG_SH + TAG_W;

  localparam int               TS_W     = ((AGE_BITS > SET_W) ? AGE_BITS : SET_W) + 2;
  localparam logic [TS_W-1:0]  AGE_SAT  = TS_W'((64'd1 << AGE_BITS) - 64'd1);
  localparam logic [SET_W-1:0] SET_LAST = SET_W'(SETS - 1);

  typedef struct packed {
    logic             valid;
    logic             sat;
    logic [TAG_W-1:0] tag;
    logic [TS_W-1:0]  stamp;
  } line_t;

  typedef line_t [NUM_WAYS-1:0] row_t;

  typedef enum logic [2:0] {CLEAR, IDLE, READ, LOOK, UPDATE} state_t;

  state_t                              state;
  logic [POLICY_W-1:0]                 policy;
  logic [AW-1:0]                       addr_in;
  logic [AW-1:0]                       addr_q;
  logic [BLK_PW-1:0]                   blk_prod;
  logic [TAG_PW-1:0]                   tag_prod;
  logic [BLK_W-1:0]                    blk_q;
  logic [TAG_W-1:0]                    tag_q;
  logic [SET_W-1:0]                    set_calc;
  logic [SET_W-1:0]                    set_q;
  logic [OFF_W-1:0]                    word_q;
  logic [SET_W-1:0]                    ptr;
  logic [TS_W-1:0]                     now;
  row_t                                rd_a;
  row_t                                rd_b;
  row_t                                scrub_row;
  row_t                                upd_row;
  row_t                                ram_wdata;
  logic                                ram_we;
  logic [SET_W-1:0]                    ram_waddr;
  logic [NUM_WAYS-1:0]                 look_hit;
  logic [NUM_WAYS-1:0]                 look_valid;
  logic [NUM_WAYS-1:0][AGE_BITS-1:0]   look_age;
  logic [NUM_WAYS-1:0]                 hit_vec_q;
  logic [NUM_WAYS-1:0]                 valid_vec_q;
  logic [NUM_WAYS-1:0][AGE_BITS-1:0]   age_q;
  logic                                hit_any;
  logic                                all_valid;
  logic                                touch;
  logic                                upd_fire;
  logic                                miss_bump;
  logic [WAY_W-1:0]                    hit_way;
  logic [WAY_W-1:0]                    empty_way;
  logic [WAY_W-1:0]                    victim_way;
  logic [WAY_W-1:0]                    sel_way;

  function automatic logic [WAY_W-1:0] pick_way(
    input logic [NUM_WAYS-1:0][AGE_BITS-1:0] ages,
    input logic                              youngest
  );
    logic [WAYS_P-1:0][AGE_BITS-1:0] a;
    logic [WAYS_P-1:0][WAY_W-1:0]    idx;
    logic                            right;
    for (int i = 0; i < WAYS_P; i++) begin
      idx[i] = WAY_W'(i);
      if (i < NUM_WAYS) begin
        a[i] = ages[i];
      end else begin
        a[i] = youngest ? '1 : '0;
      end
    end
    for (int l = 0; l < WAY_W; l++) begin
      for (int i = 0; i < (WAYS_P >> (l + 1)); i++) begin
        right  = youngest ? (a[2*i+1] < a[2*i]) : (a[2*i+1] > a[2*i]);
        a[i]   = right ? a[2*i+1] : a[2*i];
        idx[i] = right ? idx[2*i+1] : idx[2*i];
      end
    end
    return idx[0];
  endfunction

  assign addr_in   = AW'(address);
  assign blk_prod  = BLK_PW'(addr_in) * BLK_PW'(BLK_MUL);
  assign tag_prod  = TAG_PW'(addr_in) * TAG_PW'(TAG_MUL);
  assign set_calc  = SET_W'(blk_q - BLK_W'(BLK_W'(tag_q) * BLK_W'(SETS)));
  assign in_ready  = (state == IDLE);
  assign upd_fire  = (state == UPDATE) && (!out_valid || out_ready);
  assign miss_bump = upd_fire && !hit_any && (miss_count != '1);

  always_comb begin
    logic [TS_W-1:0] diff_a;
    logic [TS_W-1:0] diff_b;
    scrub_row = rd_b;
    for (int w = 0; w < NUM_WAYS; w++) begin
      diff_a        = now - rd_a[w].stamp;
      diff_b        = now - rd_b[w].stamp;
      look_hit[w]   = rd_a[w].valid && (rd_a[w].tag == tag_q);
      look_valid[w] = rd_a[w].valid;
      look_age[w]   = (rd_a[w].sat || (diff_a >= AGE_SAT)) ? '1 : diff_a[AGE_BITS-1:0];
      if (rd_b[w].valid && (diff_b >= AGE_SAT)) begin
        scrub_row[w].sat = 1'b1;
      end
    end
  end

  always_comb begin
    hit_any    = |hit_vec_q;
    all_valid  = &valid_vec_q;
    hit_way    = '0;
    empty_way  = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (hit_vec_q[w]) begin
        hit_way = WAY_W'(w);
      end
      if (!valid_vec_q[w]) begin
        empty_way = WAY_W'(w);
      end
    end
    victim_way = pick_way(age_q, policy == POLICY_MRU);
    sel_way    = hit_any ? hit_way : (all_valid ? victim_way : empty_way);
    touch      = !hit_any || (policy != POLICY_FIFO);
    upd_row    = rd_a;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (age_q[w] == '1) begin
        upd_row[w].sat = 1'b1;
      end
      if ((WAY_W'(w) == sel_way) && touch) begin
        upd_row[w].valid = 1'b1;
        upd_row[w].sat   = 1'b0;
        upd_row[w].stamp = now;
        if (!hit_any) begin
          upd_row[w].tag = tag_q;
        end
      end
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr;
    ram_wdata = '0;
    case (state)
      CLEAR: begin
        ram_we = 1'b1;
      end
      LOOK: begin
        ram_we    = (ptr != set_q);
        ram_wdata = scrub_row;
      end
      UPDATE: begin
        ram_we    = upd_fire;
        ram_waddr = set_q;
        ram_wdata = upd_row;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  sacr_ram #(
    .WIDTH ($bits(row_t)),
    .DEPTH (SETS)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (set_calc),
    .rdata_a (rd_a),
    .raddr_b (ptr),
    .rdata_b (rd_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= CLEAR;
      policy     <= POLICY_FIFO;
      ptr        <= '0;
      now        <= '0;
      out_valid  <= 1'b0;
      hit_count  <= '0;
      miss_count <= '0;
    end else begin
      if (cfg_we) begin
        policy <= cfg_wdata;
      end
      if (out_valid && out_ready && !upd_fire) begin
        out_valid <= 1'b0;
      end
      case (state)
        CLEAR: begin
          if (ptr == SET_LAST) begin
            ptr   <= '0;
            state <= IDLE;
          end else begin
            ptr <= ptr + SET_W'(1);
          end
        end
        IDLE: begin
          if (in_valid) begin
            addr_q <= addr_in;
            blk_q  <= blk_prod[BLK_SH +: BLK_W];
            tag_q  <= tag_prod[TAG_SH +: TAG_W];
            state  <= READ;
          end
        end
        READ: begin
          set_q  <= set_calc;
          word_q <= OFF_W'(addr_q - AW'(AW'(blk_q) * AW'(WPB)));
          state  <= LOOK;
        end
        LOOK: begin
          hit_vec_q   <= look_hit;
          valid_vec_q <= look_valid;
          age_q       <= look_age;
          state       <= UPDATE;
        end
        UPDATE: begin
          if (upd_fire) begin
            out_valid   <= 1'b1;
            hit         <= hit_any;
            set_index   <= SET_INDEX_W'(set_q);
            way         <= WAY_OUT_W'(sel_way);
            word_offset <= WORD_OFFSET_W'(word_q);
            evicted     <= !hit_any && all_valid;
            if (hit_any) begin
              if (hit_count != '1) begin
                hit_count <= hit_count + COUNT_W'(1);
              end
            end else if (miss_bump) begin
              miss_count <= miss_count + COUNT_W'(1);
            end
            now   <= now + TS_W'(1);
            ptr   <= (ptr == SET_LAST) ? '0 : ptr + SET_W'(1);
            state <= IDLE;
          end
        end
        default: begin
          state <= CLEAR;
        end
      endcase
    end
  end

  `SACR_ASSERT(a_single_hit, (state != UPDATE) || $onehot0(hit_vec_q), "tag held in two ways")
  `SACR_ASSERT(a_ptr_range, ptr <= SET_LAST, "sweep pointer beyond last set")
  `SACR_ASSERT_NEXT(a_miss_step, miss_bump, miss_count != $past(miss_count), "miss count held")
  `SACR_ASSERT_IMPL(a_hit_no_evict, out_valid, !(hit && evicted), "eviction reported on a hit")

endmodule

`default_nettype wire
